// ----- design/stl_pkg.sv -----
// ============================================================================
// stl_pkg
// Shared types, token and mode codes, keyword tables and byte classifiers
// for the source token lexer.
// ============================================================================
`default_nettype none

package stl_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int TOK_W           = 24;
    localparam logic [TOK_W-1:0] TOK_MAX = '1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int KW_SLOTS = 8;
    localparam logic [KW_SLOTS-1:0] KW_ALL = '1;

    // byte codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SLASH  = 8'h2F;

    typedef enum logic [4:0] {
        K_COMMA   = 5'd0,
        K_DOT     = 5'd1,
        K_EQUAL   = 5'd2,
        K_GT      = 5'd3,
        K_LT      = 5'd4,
        K_LBRACE  = 5'd5,
        K_RBRACE  = 5'd6,
        K_LBRACK  = 5'd7,
        K_RBRACK  = 5'd8,
        K_LPAREN  = 5'd9,
        K_RPAREN  = 5'd10,
        K_AMP     = 5'd11,
        K_BAR     = 5'd12,
        K_MINUS   = 5'd13,
        K_BANG    = 5'd14,
        K_PLUS    = 5'd15,
        K_SEMI    = 5'd16,
        K_STAR    = 5'd17,
        K_SLASH   = 5'd18,
        K_NUMBER  = 5'd19,
        K_CHAR    = 5'd20,
        K_STRING  = 5'd21,
        K_KEYWORD = 5'd22,
        K_IDENT   = 5'd23,
        K_ERROR   = 5'd24,
        K_END     = 5'd25
    } t_kind;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_SLASH   = 4'd1,
        M_COMMENT = 4'd2,
        M_NUMBER  = 4'd3,
        M_IDENT   = 4'd4,
        M_CHAR1   = 4'd5,
        M_CHAR2   = 4'd6,
        M_STRING  = 4'd7,
        M_ERROR   = 4'd8
    } t_mode;

    typedef struct packed {
        t_kind            kind;
        logic [TOK_W-1:0] start;
        logic [TOK_W-1:0] length;
        logic [2:0]       kw;
        logic [7:0]       ch;
        logic             last;
    } t_token;

    // zero, one or two tokens produced by one byte
    typedef struct packed {
        logic [1:0] n;
        t_token     tok0;
        t_token     tok1;
    } t_step;

    typedef struct packed {
        logic  hit;
        t_kind kind;
    } t_punct;

    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
    } t_kwsel;

    // func, if, else, return, struct, while, sizeof, new
    localparam logic [7:0] KW_TEXT [KW_SLOTS][KW_SLOTS] = '{
        '{"f", "u", "n", "c", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"i", "f", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"e", "l", "s", "e", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"r", "e", "t", "u", "r", "n", CH_NUL, CH_NUL},
        '{"s", "t", "r", "u", "c", "t", CH_NUL, CH_NUL},
        '{"w", "h", "i", "l", "e", CH_NUL, CH_NUL, CH_NUL},
        '{"s", "i", "z", "e", "o", "f", CH_NUL, CH_NUL},
        '{"n", "e", "w", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}
    };
    localparam logic [2:0] KW_LEN [KW_SLOTS] = '{
        3'd4, 3'd2, 3'd4, 3'd6, 3'd6, 3'd5, 3'd6, 3'd3
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
    endfunction

    function automatic t_punct punct_code(input logic [7:0] c);
        t_punct p;
        p.hit  = 1'b1;
        p.kind = K_COMMA;
        case (c)
            ",": p.kind = K_COMMA;
            ".": p.kind = K_DOT;
            "=": p.kind = K_EQUAL;
            ">": p.kind = K_GT;
            "<": p.kind = K_LT;
            "{": p.kind = K_LBRACE;
            "}": p.kind = K_RBRACE;
            "[": p.kind = K_LBRACK;
            "]": p.kind = K_RBRACK;
            "(": p.kind = K_LPAREN;
            ")": p.kind = K_RPAREN;
            "&": p.kind = K_AMP;
            "|": p.kind = K_BAR;
            "-": p.kind = K_MINUS;
            "!": p.kind = K_BANG;
            "+": p.kind = K_PLUS;
            ";": p.kind = K_SEMI;
            "*": p.kind = K_STAR;
            default: p.hit = 1'b0;
        endcase
        return p;
    endfunction

    // keep the keywords whose character at idx matches c
    function automatic logic [KW_SLOTS-1:0] kw_narrow(input logic [KW_SLOTS-1:0] cand,
                                                      input logic [2:0] idx,
                                                      input logic idx_ok,
                                                      input logic [7:0] c);
        logic [KW_SLOTS-1:0] keep;
        for (int k = 0; k < KW_SLOTS; k++) begin
            keep[k] = cand[k] && idx_ok && (idx < KW_LEN[k]) && (KW_TEXT[k][idx] == c);
        end
        return keep;
    endfunction

    // lowest surviving keyword whose length equals the word length
    function automatic t_kwsel kw_pick(input logic [KW_SLOTS-1:0] cand,
                                       input logic [2:0] len,
                                       input logic len_ok);
        t_kwsel sel;
        sel.hit = 1'b0;
        sel.idx = 3'd0;
        for (int k = KW_SLOTS - 1; k >= 0; k--) begin
            if (cand[k] && len_ok && (len == KW_LEN[k])) begin
                sel.hit = 1'b1;
                sel.idx = 3'(k);
            end
        end
        return sel;
    endfunction

    function automatic t_token mk_token(input t_kind kind,
                                        input logic [TOK_W-1:0] start,
                                        input logic [TOK_W-1:0] length,
                                        input logic [2:0] kw,
                                        input logic [7:0] ch);
        t_token t;
        t.kind   = kind;
        t.start  = start;
        t.length = length;
        t.kw     = kw;
        t.ch     = ch;
        t.last   = 1'b0;
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- design/stl_lex_stage.sv -----
// ============================================================================
// stl_lex_stage
// Lexer state registers and the per-byte step: next mode, offsets, keyword
// mask, and up to two tokens for the result queue.
// ============================================================================
`default_nettype none

module stl_lex_stage
    import stl_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_end,
    output t_step           o_step
);

    localparam int WW = (OFFSET_BITS > TOK_W) ? OFFSET_BITS : TOK_W;

    t_mode                   r_mode, n_mode;
    logic [OFFSET_BITS-1:0]  r_pos, n_pos;
    logic [OFFSET_BITS-1:0]  r_pstart, n_pstart;
    logic [OFFSET_BITS-1:0]  r_plen, n_plen;
    logic [KW_SLOTS-1:0]     r_kcand, n_kcand;
    logic [7:0]              r_held, n_held;

    logic                    end_in;
    logic [OFFSET_BITS-1:0]  pos_p1;
    logic [OFFSET_BITS-1:0]  plen_grow;
    logic                    idx_ok;
    logic [WW-1:0]           pos_w, pstart_w, plen_w;
    logic [TOK_W-1:0]        pos_t, pstart_t, plen_t;
    logic                    alnum;

    // start-of-token decode, used from idle and after a token ends
    t_punct                  punct;
    logic                    st_emit;
    t_token                  st_tok;
    t_mode                   st_mode;
    logic [OFFSET_BITS-1:0]  st_start, st_len;
    logic [KW_SLOTS-1:0]     st_kcand;

    logic                    take_start;
    t_kwsel                  kw_sel;
    t_token                  word_tok;
    logic                    a_v, b_v;
    t_token                  a_tok, b_tok;

    assign end_in    = i_end || (i_byte == CH_NUL);
    assign pos_p1    = r_pos + OFFSET_BITS'(1);
    assign plen_grow = (r_plen == '1) ? r_plen : r_plen + OFFSET_BITS'(1);
    assign idx_ok    = r_plen < OFFSET_BITS'(KW_SLOTS);
    assign alnum     = is_letter(i_byte) || is_digit(i_byte);

    assign pos_w    = WW'(r_pos);
    assign pstart_w = WW'(r_pstart);
    assign plen_w   = WW'(r_plen);
    assign pos_t    = pos_w[TOK_W-1:0];
    assign pstart_t = pstart_w[TOK_W-1:0];
    assign plen_t   = (plen_w > WW'(TOK_MAX)) ? TOK_MAX : plen_w[TOK_W-1:0];

    always_comb begin
        punct    = punct_code(i_byte);
        st_emit  = 1'b0;
        st_tok   = mk_token(K_ERROR, pos_t, '0, '0, '0);
        st_mode  = M_IDLE;
        st_start = r_pstart;
        st_len   = r_plen;
        st_kcand = r_kcand;
        if (!is_blank(i_byte)) begin
            if (punct.hit) begin
                st_emit = 1'b1;
                st_tok  = mk_token(punct.kind, pos_t, TOK_W'(1), '0, '0);
            end else if (i_byte == CH_SLASH) begin
                st_start = r_pos;
                st_mode  = M_SLASH;
            end else if (is_digit(i_byte)) begin
                st_start = r_pos;
                st_len   = OFFSET_BITS'(1);
                st_mode  = M_NUMBER;
            end else if (is_letter(i_byte)) begin
                st_start = r_pos;
                st_len   = OFFSET_BITS'(1);
                st_kcand = kw_narrow(KW_ALL, 3'd0, 1'b1, i_byte);
                st_mode  = M_IDENT;
            end else if (i_byte == CH_SQUOTE) begin
                st_start = pos_p1;
                st_mode  = M_CHAR1;
            end else if (i_byte == CH_DQUOTE) begin
                st_start = pos_p1;
                st_len   = '0;
                st_mode  = M_STRING;
            end else begin
                st_emit = 1'b1;
                st_mode = M_ERROR;
            end
        end
    end

    // next state
    always_comb begin
        take_start = 1'b0;
        n_mode     = r_mode;
        n_pos      = r_pos;
        n_pstart   = r_pstart;
        n_plen     = r_plen;
        n_kcand    = r_kcand;
        n_held     = r_held;
        if (end_in) begin
            n_mode   = M_IDLE;
            n_pos    = '0;
            n_pstart = '0;
            n_plen   = '0;
            n_kcand  = KW_ALL;
            n_held   = '0;
        end else begin
            n_pos = pos_p1;
            case (r_mode)
                M_ERROR: begin
                    n_mode = M_ERROR;
                end
                M_COMMENT: begin
                    if (i_byte == CH_NL) n_mode = M_IDLE;
                end
                M_SLASH: begin
                    if (i_byte == CH_SLASH) n_mode = M_COMMENT;
                    else                    take_start = 1'b1;
                end
                M_NUMBER: begin
                    if (is_digit(i_byte)) n_plen = plen_grow;
                    else                  take_start = 1'b1;
                end
                M_IDENT: begin
                    if (alnum) begin
                        n_kcand = kw_narrow(r_kcand, r_plen[2:0], idx_ok, i_byte);
                        n_plen  = plen_grow;
                    end else begin
                        take_start = 1'b1;
                    end
                end
                M_CHAR1: begin
                    if (i_byte == CH_SQUOTE) begin
                        n_mode = M_ERROR;
                    end else begin
                        n_held = i_byte;
                        n_mode = M_CHAR2;
                    end
                end
                M_CHAR2: begin
                    n_mode = (i_byte == CH_SQUOTE) ? M_IDLE : M_ERROR;
                end
                M_STRING: begin
                    if (i_byte == CH_DQUOTE) n_mode = M_IDLE;
                    else                     n_plen = plen_grow;
                end
                default: begin
                    take_start = 1'b1;
                end
            endcase
            if (take_start) begin
                n_mode   = st_mode;
                n_pstart = st_start;
                n_plen   = st_len;
                n_kcand  = st_kcand;
            end
        end
    end

    // tokens: a is the pending or closing token, b the one this byte starts
    always_comb begin
        kw_sel   = kw_pick(r_kcand, r_plen[2:0], idx_ok);
        word_tok = kw_sel.hit ? mk_token(K_KEYWORD, pstart_t, plen_t, kw_sel.idx, '0)
                              : mk_token(K_IDENT, pstart_t, plen_t, '0, '0);
        a_v   = 1'b0;
        a_tok = mk_token(K_ERROR, pos_t, '0, '0, '0);
        b_v   = 1'b0;
        b_tok = st_tok;
        if (end_in) begin
            case (r_mode)
                M_NUMBER: begin
                    a_v   = 1'b1;
                    a_tok = mk_token(K_NUMBER, pstart_t, plen_t, '0, '0);
                end
                M_IDENT: begin
                    a_v   = 1'b1;
                    a_tok = word_tok;
                end
                M_SLASH: begin
                    a_v   = 1'b1;
                    a_tok = mk_token(K_SLASH, pstart_t, TOK_W'(1), '0, '0);
                end
                M_CHAR1, M_CHAR2, M_STRING: begin
                    a_v = 1'b1;
                end
                default: begin
                end
            endcase
            b_v   = 1'b1;
            b_tok = mk_token(K_END, pos_t, '0, '0, '0);
        end else begin
            case (r_mode)
                M_IDLE: begin
                    b_v = st_emit;
                end
                M_SLASH: begin
                    if (i_byte != CH_SLASH) begin
                        a_v   = 1'b1;
                        a_tok = mk_token(K_SLASH, pstart_t, TOK_W'(1), '0, '0);
                        b_v   = st_emit;
                    end
                end
                M_NUMBER: begin
                    if (!is_digit(i_byte)) begin
                        a_v   = 1'b1;
                        a_tok = mk_token(K_NUMBER, pstart_t, plen_t, '0, '0);
                        b_v   = st_emit;
                    end
                end
                M_IDENT: begin
                    if (!alnum) begin
                        a_v   = 1'b1;
                        a_tok = word_tok;
                        b_v   = st_emit;
                    end
                end
                M_CHAR1: begin
                    a_v = (i_byte == CH_SQUOTE);
                end
                M_CHAR2: begin
                    a_v = 1'b1;
                    if (i_byte == CH_SQUOTE) begin
                        a_tok = mk_token(K_CHAR, pstart_t, TOK_W'(1), '0, r_held);
                    end
                end
                M_STRING: begin
                    if (i_byte == CH_DQUOTE) begin
                        a_v   = 1'b1;
                        a_tok = mk_token(K_STRING, pstart_t, plen_t, '0, '0);
                    end
                end
                default: begin
                end
            endcase
        end

        o_step.n         = {1'b0, a_v} + {1'b0, b_v};
        o_step.tok0      = a_v ? a_tok : b_tok;
        o_step.tok0.last = !(a_v && b_v);
        o_step.tok1      = b_tok;
        o_step.tok1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_pos    <= '0;
            r_pstart <= '0;
            r_plen   <= '0;
            r_kcand  <= KW_ALL;
            r_held   <= '0;
        end else if (i_fire) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_pstart <= n_pstart;
            r_plen   <= n_plen;
            r_kcand  <= n_kcand;
            r_held   <= n_held;
        end
    end

endmodule

`default_nettype wire

// ----- design/stl_token_fifo.sv -----
// ============================================================================
// stl_token_fifo
// Small result queue: takes up to two tokens per cycle, hands out one.
// ============================================================================
`default_nettype none

module stl_token_fifo
    import stl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_step                 i_push,
    input  wire logic                  i_pop,
    output t_token                     o_head,
    output logic [FIFO_CNT_W-1:0]      o_count
);

    t_token                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   r_wr, n_wr;
    logic [FIFO_PTR_W-1:0]   r_rd, n_rd;
    logic [FIFO_CNT_W-1:0]   r_count, n_count;
    logic [FIFO_PTR_W-1:0]   wr_next;

    assign wr_next = r_wr + FIFO_PTR_W'(1);
    assign n_wr    = r_wr + FIFO_PTR_W'(i_push.n);
    assign n_rd    = i_pop ? r_rd + FIFO_PTR_W'(1) : r_rd;
    assign n_count = r_count + FIFO_CNT_W'(i_push.n) - FIFO_CNT_W'(i_pop);

    assign o_head  = r_mem[r_rd];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) r_mem[r_wr]    <= i_push.tok0;
        if (i_push.n == 2'd2) r_mem[wr_next] <= i_push.tok1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ----- design/source_token_lexer_unit.sv -----
// ============================================================================
// source_token_lexer_unit
// Streaming lexer: one source byte in per transfer, tokens out per transfer.
// ============================================================================
// Input channel: i_valid / o_stall carry one source byte (or the end marker,
// i_is_end, or a zero byte) per transfer. Output channel: o_valid / i_stall
// carry one token per transfer: kind, start offset, length, keyword index,
// character value, and o_last_of_run on the final token caused by a byte.
// A byte gives zero, one or two tokens.
// A token appears at o_valid once the byte that completes it has passed
// the input register and then the lexer step writing the result queue.
// Throughput: one byte per cycle while the queue drains; a byte that gives
// two tokens needs two output transfers, which the four-entry queue absorbs.
// The lexer step fires only when the queue has two free slots, counting a
// token leaving in the same cycle.
// Reset (synchronous, active low): lexer idle, offsets zero, queue empty.
// An end marker also returns the lexer to its reset state after its tokens.
// When the receiver stalls, the queue fills, the step waits, and o_stall
// rises once the input register holds a byte it cannot yet process.
// ============================================================================
`default_nettype none

module source_token_lexer_unit
    import stl_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_source_byte,
    input  wire logic        i_is_end,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [4:0]       o_token_kind,
    output logic [23:0]      o_token_start,
    output logic [23:0]      o_token_length,
    output logic [2:0]       o_keyword_index,
    output logic [7:0]       o_char_value,
    output logic             o_last_of_run
);

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_end;

    logic                  lex_fire;
    logic                  fifo_room;
    logic                  fifo_pop;
    logic [FIFO_CNT_W-1:0] fifo_count;
    t_step                 step;
    t_step                 push;
    t_token                head;

    // room for two tokens, counting the one leaving this cycle
    assign fifo_room = (fifo_count <= FIFO_CNT_W'(FIFO_DEPTH - 2)) ||
                       ((fifo_count == FIFO_CNT_W'(FIFO_DEPTH - 1)) && fifo_pop);
    assign lex_fire  = r_in_valid && fifo_room;
    assign o_stall   = r_in_valid && !lex_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_source_byte;
            r_in_end  <= i_is_end;
        end
    end

    stl_lex_stage #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_lex (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (lex_fire),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .o_step  (step)
    );

    always_comb begin
        push   = step;
        push.n = lex_fire ? step.n : 2'd0;
    end

    assign fifo_pop = o_valid && !i_stall;

    stl_token_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (fifo_pop),
        .o_head  (head),
        .o_count (fifo_count)
    );

    assign o_valid         = (fifo_count != '0);
    assign o_token_kind    = head.kind;
    assign o_token_start   = head.start;
    assign o_token_length  = head.length;
    assign o_keyword_index = head.kw;
    assign o_char_value    = head.ch;
    assign o_last_of_run   = head.last;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result queue not empty after reset");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_token_kind == K_END)) |-> o_last_of_run)
        else $error("end token not marked last of run");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !lex_fire) |=> r_in_valid)
        else $error("waiting byte dropped from input register");
`endif

endmodule

`default_nettype wire
